>>> hw/rtl/fa2p_pkg.sv
`default_nettype none

package fa2p_pkg;

   // magnitude of a 32-bit signed input, saturated
   localparam int MagWidth    = 31;
   localparam int InWidth     = 32;
   localparam int AngleWidth  = 19;
   localparam int CoefCount   = 6;
   localparam int RefFracBits = 16;
   localparam int Q30Bits     = 30;

   // pi and pi/2, Q2.30, truncated
   localparam longint unsigned PiQ30     = 64'd3373259426;
   localparam longint unsigned HalfPiQ30 = 64'd1686629713;

   // odd arctangent polynomial, Q16, highest order first
   localparam int Coef16 [CoefCount] = '{-883, 3767, -7946, 12821, -21823, 65536};

   typedef struct packed {
      logic swap;    // |y| > |x|
      logic x_neg;
      logic y_neg;
      logic zero;    // both inputs zero
   } octant_type;

   // rescale a Q16 coefficient, truncating toward zero
   function automatic longint scale_coef(input int c16, input int frac_bits);
      longint mag;
      logic   neg;
      neg = (c16 < 0);
      mag = neg ? -longint'(c16) : longint'(c16);
      if (frac_bits >= RefFracBits) begin
         mag = mag << (frac_bits - RefFracBits);
      end else begin
         mag = mag >> (RefFracBits - frac_bits);
      end
      return neg ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fa2p_prep.sv
`default_nettype none

module fa2p_prep
   import fa2p_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic signed [InWidth-1:0]  in_y,
   input  wire logic signed [InWidth-1:0]  in_x,
   output logic                            out_valid,
   output logic [MagWidth-1:0]             out_big,
   output logic [MagWidth-1:0]             out_small,
   output octant_type                      out_oct
);

   logic signed [InWidth-1:0] neg_y;
   logic signed [InWidth-1:0] neg_x;
   logic [MagWidth-1:0]       ay_in, ax_in;
   logic [MagWidth-1:0]       ay_ff, ax_ff;
   logic                      yneg_ff, xneg_ff;
   logic                      v1_ff;

   logic                      swap;
   octant_type                oct_in, oct_ff;
   logic [MagWidth-1:0]       big_in, small_in, big_ff, small_ff;
   logic                      v2_ff;

   // stage 1: magnitudes, most negative value saturates
   always_comb begin
      neg_y = -in_y;
      neg_x = -in_x;
      ay_in = in_y[InWidth-1] ? (neg_y[InWidth-1] ? '1 : neg_y[MagWidth-1:0])
                              : in_y[MagWidth-1:0];
      ax_in = in_x[InWidth-1] ? (neg_x[InWidth-1] ? '1 : neg_x[MagWidth-1:0])
                              : in_x[MagWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      ay_ff   <= ay_in;
      ax_ff   <= ax_in;
      yneg_ff <= in_y[InWidth-1];
      xneg_ff <= in_x[InWidth-1];
   end

   // stage 2: order the magnitudes
   always_comb begin
      swap         = (ay_ff > ax_ff);
      big_in       = swap ? ay_ff : ax_ff;
      small_in     = swap ? ax_ff : ay_ff;
      oct_in.swap  = swap;
      oct_in.x_neg = xneg_ff;
      oct_in.y_neg = yneg_ff;
      oct_in.zero  = ((ay_ff | ax_ff) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      big_ff   <= big_in;
      small_ff <= small_in;
      oct_ff   <= oct_in;
   end

   assign out_valid = v2_ff;
   assign out_big   = big_ff;
   assign out_small = small_ff;
   assign out_oct   = oct_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fa2p_div_step.sv
`default_nettype none

module fa2p_div_step
   import fa2p_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter bit FIRST     = 1'b0
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [MagWidth-1:0]   in_rem,
   input  wire logic [MagWidth-1:0]   in_div,
   input  wire logic [FRAC_BITS:0]    in_quo,
   input  wire octant_type            in_oct,
   output logic                       out_valid,
   output logic [MagWidth-1:0]        out_rem,
   output logic [MagWidth-1:0]        out_div,
   output logic [FRAC_BITS:0]         out_quo,
   output octant_type                 out_oct
);

   localparam int QuoWidth = FRAC_BITS + 1;

   logic [MagWidth:0]   part;
   logic [MagWidth+1:0] diff;
   logic                take;
   logic [MagWidth-1:0] rem_in, rem_ff, div_ff;
   logic [QuoWidth-1:0] quo_in, quo_ff;
   octant_type          oct_ff;
   logic                valid_ff;

   // restoring step: one quotient bit; low dividend bits are all zero
   always_comb begin
      part   = FIRST ? {1'b0, in_rem} : {in_rem, 1'b0};
      diff   = {1'b0, part} - {2'b00, in_div};
      take   = ~diff[MagWidth+1];
      rem_in = take ? diff[MagWidth-1:0] : part[MagWidth-1:0];
      quo_in = {in_quo[QuoWidth-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_ff <= rem_in;
      div_ff <= in_div;
      quo_ff <= quo_in;
      oct_ff <= in_oct;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_quo   = quo_ff;
   assign out_oct   = oct_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fa2p_mac_stage.sv
`default_nettype none

module fa2p_mac_stage
   import fa2p_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic signed [FRAC_BITS+1:0] in_a,
   input  wire logic [FRAC_BITS:0]          in_m,
   input  wire logic signed [FRAC_BITS+1:0] in_c,
   input  wire logic [2*FRAC_BITS+1:0]      in_side,
   input  wire octant_type                  in_oct,
   output logic                             out_valid,
   output logic signed [FRAC_BITS+1:0]      out_acc,
   output logic [2*FRAC_BITS+1:0]           out_side,
   output octant_type                       out_oct
);

   localparam int AccWidth  = FRAC_BITS + 2;
   localparam int ProdWidth = 2 * AccWidth;

   logic signed [ProdWidth-1:0] prod;
   logic signed [ProdWidth-1:0] shifted;
   logic signed [AccWidth-1:0]  acc_in, acc_ff;
   logic [2*FRAC_BITS+1:0]      side_ff;
   octant_type                  oct_ff;
   logic                        valid_ff;

   // a*m floored to the fraction width, then plus c
   always_comb begin
      prod    = in_a * $signed({1'b0, in_m});
      shifted = prod >>> FRAC_BITS;
      acc_in  = $signed(shifted[AccWidth-1:0]) + in_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      acc_ff  <= acc_in;
      side_ff <= in_side;
      oct_ff  <= in_oct;
   end

   assign out_valid = valid_ff;
   assign out_acc   = acc_ff;
   assign out_side  = side_ff;
   assign out_oct   = oct_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fa2p_fold.sv
`default_nettype none

module fa2p_fold
   import fa2p_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic signed [FRAC_BITS+1:0] in_acc,
   input  wire logic [FRAC_BITS:0]          in_r,
   input  wire octant_type                  in_oct,
   output logic                             out_valid,
   output logic [AngleWidth-1:0]            out_angle
);

   localparam int AccWidth  = FRAC_BITS + 2;
   localparam int QuoWidth  = FRAC_BITS + 1;
   localparam int ProdWidth = 2 * AccWidth;
   localparam int ExtWidth  = (FRAC_BITS + 3 > AngleWidth) ? FRAC_BITS + 3 : AngleWidth;
   localparam longint unsigned PiFrac     = PiQ30 >> (Q30Bits - FRAC_BITS);
   localparam longint unsigned HalfPiFrac = HalfPiQ30 >> (Q30Bits - FRAC_BITS);
   localparam logic [ExtWidth-1:0] PiExt     = ExtWidth'(PiFrac);
   localparam logic [ExtWidth-1:0] HalfPiExt = ExtWidth'(HalfPiFrac);

   logic signed [ProdWidth-1:0] prod;
   logic [QuoWidth-1:0]         ang_in, ang_ff;
   octant_type                  oct_ff;
   logic                        va_ff;

   logic [ExtWidth-1:0]         base;
   logic [ExtWidth-1:0]         ang_ext;
   logic [ExtWidth-1:0]         sum;
   logic                        neg;
   logic [AngleWidth-1:0]       angle_in, angle_ff;
   logic                        vb_ff;

   // stage A: first-octant angle r * p(r^2), never negative
   always_comb begin
      prod   = $signed({1'b0, in_r}) * in_acc;
      ang_in = prod[FRAC_BITS+QuoWidth-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
      ang_ff <= ang_in;
      oct_ff <= in_oct;
   end

   // stage B: the three reflections fold into base +/- angle
   always_comb begin
      base = oct_ff.swap ? HalfPiExt : '0;
      if (oct_ff.x_neg) begin
         base = PiExt - base;
      end
      if (oct_ff.y_neg) begin
         base = '0 - base;
      end
      neg      = oct_ff.swap ^ oct_ff.x_neg ^ oct_ff.y_neg;
      ang_ext  = ExtWidth'(ang_ff);
      sum      = base + (ang_ext ^ {ExtWidth{neg}}) + ExtWidth'(neg);
      angle_in = oct_ff.zero ? '0 : sum[AngleWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      angle_ff <= angle_in;
   end

   assign out_valid = vb_ff;
   assign out_angle = angle_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fixed_atan2_polynomial.sv
`default_nettype none

// Four-quadrant arctangent of signed fixed-point y and x (FRAC_BITS fraction
// bits), angle returned in radians in the same format, 19 bits, -pi..pi.
//
// Request: pulse start with req_y_value/req_x_value; taken on an edge where
// start is high and busy is low. busy is high only during reset and the
// cycle after it, so a new request can be given on every clock.
// Response: rsp_angle is valid for the single cycle rsp_strobe is high. The
// receiver has no way to hold it off and must take it then.
// Pipeline from the accepting edge to the strobe: 2 magnitude/order stages,
// one restoring divider stage per quotient bit (FRAC_BITS + 1), 6 multiply-add
// stages (square plus 5 Horner steps), final multiply, octant fold.
// Throughput: one request per cycle.
// Reset clears every stage's valid bit; requests in flight are dropped.
// Both inputs zero give 0; a most negative input saturates to 2^31 - 1.

module fixed_atan2_polynomial
   import fa2p_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic signed [InWidth-1:0]  req_y_value,
   input  wire logic signed [InWidth-1:0]  req_x_value,
   output logic                            rsp_strobe,
   output logic signed [AngleWidth-1:0]    rsp_angle
);

   localparam int AccWidth  = FRAC_BITS + 2;
   localparam int QuoWidth  = FRAC_BITS + 1;
   localparam int SideWidth = 2 * QuoWidth;
   localparam int DivStages = FRAC_BITS + 1;
   localparam int MacStages = CoefCount;

   // polynomial coefficients at this fraction width
   localparam logic signed [AccWidth-1:0] Coef [CoefCount] = '{
      AccWidth'(scale_coef(Coef16[0], FRAC_BITS)),
      AccWidth'(scale_coef(Coef16[1], FRAC_BITS)),
      AccWidth'(scale_coef(Coef16[2], FRAC_BITS)),
      AccWidth'(scale_coef(Coef16[3], FRAC_BITS)),
      AccWidth'(scale_coef(Coef16[4], FRAC_BITS)),
      AccWidth'(scale_coef(Coef16[5], FRAC_BITS))
   };

   logic busy_ff;
   logic accept;

   // front end
   logic                  prep_valid;
   logic [MagWidth-1:0]   prep_big, prep_small;
   octant_type            prep_oct;

   // divider chain, element 0 is the divider input
   logic                  div_valid [0:DivStages];
   logic [MagWidth-1:0]   div_rem   [0:DivStages];
   logic [MagWidth-1:0]   div_div   [0:DivStages];
   logic [QuoWidth-1:0]   div_quo   [0:DivStages];
   octant_type            div_oct   [0:DivStages];

   // multiply-add chain: stage inputs and outputs
   logic                       mac_vi   [0:MacStages-1];
   logic signed [AccWidth-1:0] mac_a    [0:MacStages-1];
   logic [QuoWidth-1:0]        mac_m    [0:MacStages-1];
   logic signed [AccWidth-1:0] mac_c    [0:MacStages-1];
   logic [SideWidth-1:0]       mac_si   [0:MacStages-1];
   octant_type                 mac_oi   [0:MacStages-1];
   logic                       mac_vo   [0:MacStages-1];
   logic signed [AccWidth-1:0] mac_acc  [0:MacStages-1];
   logic [SideWidth-1:0]       mac_so   [0:MacStages-1];
   octant_type                 mac_oo   [0:MacStages-1];

   logic [AngleWidth-1:0]      fold_angle;

   // busy while reset is in effect and in the cycle after it
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   fa2p_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_y      (req_y_value),
      .in_x      (req_x_value),
      .out_valid (prep_valid),
      .out_big   (prep_big),
      .out_small (prep_small),
      .out_oct   (prep_oct)
   );

   // ratio small/big, one quotient bit per stage; first bit is small >= big
   assign div_valid[0] = prep_valid;
   assign div_rem[0]   = prep_small;
   assign div_div[0]   = prep_big;
   assign div_quo[0]   = '0;
   assign div_oct[0]   = prep_oct;

   for (genvar i = 0; i < DivStages; i++) begin : g_div
      fa2p_div_step #(
         .FRAC_BITS (FRAC_BITS),
         .FIRST     (i == 0)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_rem    (div_rem[i]),
         .in_div    (div_div[i]),
         .in_quo    (div_quo[i]),
         .in_oct    (div_oct[i]),
         .out_valid (div_valid[i+1]),
         .out_rem   (div_rem[i+1]),
         .out_div   (div_div[i+1]),
         .out_quo   (div_quo[i+1]),
         .out_oct   (div_oct[i+1])
      );
   end

   // side word carries {r, r^2}; stage 0 squares r, the rest are Horner steps
   for (genvar k = 0; k < MacStages; k++) begin : g_mac
      if (k == 0) begin : g_sq
         assign mac_vi[k] = div_valid[DivStages];
         assign mac_a[k]  = $signed({1'b0, div_quo[DivStages]});
         assign mac_m[k]  = div_quo[DivStages];
         assign mac_c[k]  = '0;
         assign mac_si[k] = {div_quo[DivStages], {QuoWidth{1'b0}}};
         assign mac_oi[k] = div_oct[DivStages];
      end else if (k == 1) begin : g_first
         assign mac_vi[k] = mac_vo[k-1];
         assign mac_a[k]  = Coef[0];
         assign mac_m[k]  = mac_acc[k-1][QuoWidth-1:0];
         assign mac_c[k]  = Coef[k];
         assign mac_si[k] = {mac_so[k-1][SideWidth-1:QuoWidth],
                             mac_acc[k-1][QuoWidth-1:0]};
         assign mac_oi[k] = mac_oo[k-1];
      end else begin : g_horner
         assign mac_vi[k] = mac_vo[k-1];
         assign mac_a[k]  = mac_acc[k-1];
         assign mac_m[k]  = mac_so[k-1][QuoWidth-1:0];
         assign mac_c[k]  = Coef[k];
         assign mac_si[k] = mac_so[k-1];
         assign mac_oi[k] = mac_oo[k-1];
      end

      fa2p_mac_stage #(
         .FRAC_BITS (FRAC_BITS)
      ) u_mac (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (mac_vi[k]),
         .in_a      (mac_a[k]),
         .in_m      (mac_m[k]),
         .in_c      (mac_c[k]),
         .in_side   (mac_si[k]),
         .in_oct    (mac_oi[k]),
         .out_valid (mac_vo[k]),
         .out_acc   (mac_acc[k]),
         .out_side  (mac_so[k]),
         .out_oct   (mac_oo[k])
      );
   end

   // r * p(r^2), then back into the right octant; holds the output register
   fa2p_fold #(
      .FRAC_BITS (FRAC_BITS)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mac_vo[MacStages-1]),
      .in_acc    (mac_acc[MacStages-1]),
      .in_r      (mac_so[MacStages-1][SideWidth-1:QuoWidth]),
      .in_oct    (mac_oo[MacStages-1]),
      .out_valid (rsp_strobe),
      .out_angle (fold_angle)
   );

   assign rsp_angle = $signed(fold_angle);

endmodule

`default_nettype wire
